[rtl/wrv_pkg.sv]
// ----------------------------------------------------------------------------
// wrv_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the windowed regression velocity estimator.
// ----------------------------------------------------------------------------
package wrv_pkg;

    localparam int ANGLE_W  = 12;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 32;
    localparam int SPEED_W  = 24;
    localparam int SMOOTH_W = 32;

    localparam int WIN_W    = 16;
    localparam int CNT_CFG_W = 4;
    localparam int MINT_W   = 8;
    localparam int ALPHA_W  = 9;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_MS    = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA        = 4'd3;

    localparam logic [WIN_W-1:0]     WINDOW_MS_RST    = 16'd200;
    localparam logic [CNT_CFG_W-1:0] SAMPLE_COUNT_RST = 4'd5;
    localparam logic [MINT_W-1:0]    MIN_INTERVAL_RST = 8'd20;
    localparam logic [ALPHA_W-1:0]   ALPHA_RST        = 9'd51;

    localparam logic [ALPHA_W-1:0]   ALPHA_ONE        = 9'd256;

    typedef struct packed {
        logic [WIN_W-1:0]     window_ms;
        logic [CNT_CFG_W-1:0] sample_count;
        logic [MINT_W-1:0]    min_interval_ms;
        logic [ALPHA_W-1:0]   smoothing_alpha;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic check;
        logic drop;
        logic append;
        logic sum_step;
        logic prod;
        logic diff;
        logic scale1;
        logic scale2;
        logic div_step;
        logic smooth1;
        logic smooth2;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic accept;
        logic age_over;
        logic cap_full;
        logic sum_last;
        logic div_last;
    } sta_t;

endpackage

[rtl/wrv_ctrl.sv]
// ----------------------------------------------------------------------------
// wrv_ctrl
// Sequencer: steps the datapath through unwrap, window update, regression
// sums, scaling, serial division, smoothing and result transfer.
// ----------------------------------------------------------------------------
module wrv_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  wrv_pkg::sta_t sta,
    output wrv_pkg::cmd_t cmd
);
    import wrv_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CHECK   = 4'd1;
    localparam logic [3:0] ST_AGE     = 4'd2;
    localparam logic [3:0] ST_CAP     = 4'd3;
    localparam logic [3:0] ST_APPEND  = 4'd4;
    localparam logic [3:0] ST_SUM     = 4'd5;
    localparam logic [3:0] ST_DRAIN1  = 4'd6;
    localparam logic [3:0] ST_DRAIN2  = 4'd7;
    localparam logic [3:0] ST_PROD    = 4'd8;
    localparam logic [3:0] ST_DIFF    = 4'd9;
    localparam logic [3:0] ST_SCALE1  = 4'd10;
    localparam logic [3:0] ST_SCALE2  = 4'd11;
    localparam logic [3:0] ST_DIV     = 4'd12;
    localparam logic [3:0] ST_SMOOTH1 = 4'd13;
    localparam logic [3:0] ST_SMOOTH2 = 4'd14;
    localparam logic [3:0] ST_FINISH  = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sta.accept ? ST_AGE : ST_FINISH;
            end
            ST_AGE: begin
                if (sta.age_over) begin
                    cmd.drop = 1'b1;
                end else begin
                    state_next = ST_CAP;
                end
            end
            ST_CAP: begin
                if (sta.cap_full) begin
                    cmd.drop = 1'b1;
                end else begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (sta.sum_last) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_PROD;
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SCALE1;
            end
            ST_SCALE1: begin
                cmd.scale1 = 1'b1;
                state_next = ST_SCALE2;
            end
            ST_SCALE2: begin
                cmd.scale2 = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sta.div_last) begin
                    state_next = ST_SMOOTH1;
                end
            end
            ST_SMOOTH1: begin
                cmd.smooth1 = 1'b1;
                state_next  = ST_SMOOTH2;
            end
            ST_SMOOTH2: begin
                cmd.smooth2 = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/wrv_dp.sv]
// ----------------------------------------------------------------------------
// wrv_dp
// Datapath: angle unwrap, sample window, regression sums, slope scaling,
// restoring divider, exponential smoothing and result registers.
// ----------------------------------------------------------------------------
module wrv_dp #(
    parameter int MAX_SAMPLES = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wrv_pkg::cfg_t                       cfg,
    input  wrv_pkg::cmd_t                       cmd,
    output wrv_pkg::sta_t                       sta,
    input  logic [wrv_pkg::ANGLE_W-1:0]         s_angle_count,
    input  logic [wrv_pkg::TIME_W-1:0]          s_time_ms,
    output logic signed [wrv_pkg::SPEED_W-1:0]  m_speed_rpm,
    output logic                                m_sample_taken
);
    import wrv_pkg::*;

    localparam int LOG_N  = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W  = LOG_N;
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int ST_W   = 17 + LOG_N;
    localparam int SP_W   = 32 + LOG_N;
    localparam int STP_W  = 48 + LOG_N;
    localparam int ST2_W  = 33 + LOG_N;
    localparam int PW     = 2 * LOG_N + 50;
    localparam int DIV_W  = PW + 16;
    localparam int DCNT_W = $clog2(DIV_W);

    localparam logic [DIV_W-1:0] POS_LIMIT = DIV_W'((1 << (SPEED_W - 1)) - 1);
    localparam logic [DIV_W-1:0] NEG_LIMIT = DIV_W'(1 << (SPEED_W - 1));

    // input capture and window state
    logic [ANGLE_W-1:0] angle_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               has_prev_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   win_pos_reg  [MAX_SAMPLES];
    logic [TIME_W-1:0]  win_time_reg [MAX_SAMPLES];
    logic [CNT_W-1:0]   count_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic               taken_reg;

    // regression pipeline
    logic [IDX_W-1:0]           idx_reg;
    logic                       va_reg, vb_reg;
    logic signed [16:0]         ta_reg, tb_reg;
    logic signed [31:0]         pa_reg, pb_reg;
    logic signed [48:0]         tp_reg;
    logic signed [33:0]         tt_reg;
    logic signed [ST_W-1:0]     st_reg;
    logic signed [SP_W-1:0]     sp_reg;
    logic signed [STP_W-1:0]    stp_reg;
    logic signed [ST2_W-1:0]    st2_reg;
    logic signed [PW-1:0]       prod_a_reg, prod_b_reg, prod_c_reg, prod_d_reg;
    logic signed [PW:0]         num_reg, den_reg;
    logic                       neg_reg, den_pos_reg;

    // scaling and division
    logic [DIV_W-1:0]  a_reg, tmp_reg, dv_reg, quo_reg, rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    // smoothing
    logic signed [SPEED_W-1:0]  raw_reg;
    logic signed [41:0]         p1_reg;
    logic signed [SMOOTH_W-1:0] smooth_reg;

    // combinational helpers
    logic [ANGLE_W-1:0]   ang_d;
    logic [CNT_W-1:0]     cap;
    logic [TIME_W-1:0]    t_full;
    logic [15:0]          t_sat;
    logic signed [CNT_W:0] n_s;
    logic [PW:0]          mag_w;
    logic [DIV_W-1:0]     ax;
    logic [DIV_W:0]       rem_sh;
    logic                 ge;
    logic signed [SPEED_W-1:0] raw;
    logic [ALPHA_W-1:0]   alpha_c;
    logic signed [ALPHA_W:0] w_s, a_s;
    logic signed [33:0]   p2;
    logic signed [42:0]   sm_sum;
    logic signed [SMOOTH_W:0] sh_sum;
    logic signed [SPEED_W:0]  shown;
    logic signed [SPEED_W-1:0] shown_sat;

    assign ang_d = s_angle_reg_diff(angle_reg, pos_reg[ANGLE_W-1:0]);

    function automatic logic [ANGLE_W-1:0] s_angle_reg_diff(
        input logic [ANGLE_W-1:0] a, input logic [ANGLE_W-1:0] b);
        return a - b;
    endfunction

    always_comb begin
        if (cfg.sample_count < CNT_CFG_W'(2)) begin
            cap = CNT_W'(2);
        end else if (32'(cfg.sample_count) > MAX_SAMPLES) begin
            cap = CNT_W'(MAX_SAMPLES);
        end else begin
            cap = CNT_W'(cfg.sample_count);
        end
    end

    assign sta.accept   = (count_reg == '0) ||
                          ((last_time_reg != now_reg) &&
                           ((now_reg - last_time_reg) >= TIME_W'(cfg.min_interval_ms)));
    assign sta.age_over = (count_reg != '0) &&
                          ((now_reg - win_time_reg[0]) > TIME_W'(cfg.window_ms));
    assign sta.cap_full = (count_reg >= cap);
    assign sta.sum_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign sta.div_last = (dcnt_reg == DCNT_W'(DIV_W - 1));

    assign t_full = win_time_reg[idx_reg] - win_time_reg[0];
    assign t_sat  = (|t_full[TIME_W-1:16]) ? 16'hFFFF : t_full[15:0];
    assign n_s    = signed'({1'b0, count_reg});

    assign mag_w  = num_reg[PW] ? unsigned'(-num_reg) : unsigned'(num_reg);
    assign ax     = DIV_W'(mag_w);

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign ge     = (rem_sh >= {1'b0, dv_reg});

    always_comb begin
        if (!den_pos_reg) begin
            raw = '0;
        end else if (neg_reg) begin
            raw = (quo_reg > NEG_LIMIT) ? signed'(NEG_LIMIT[SPEED_W-1:0])
                                        : -signed'(quo_reg[SPEED_W-1:0]);
        end else begin
            raw = (quo_reg > POS_LIMIT) ? signed'(POS_LIMIT[SPEED_W-1:0])
                                        : signed'(quo_reg[SPEED_W-1:0]);
        end
    end

    assign alpha_c = (cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_alpha;
    assign w_s     = signed'({1'b0, ALPHA_ONE - alpha_c});
    assign a_s     = signed'({1'b0, alpha_c});
    assign p2      = raw_reg * a_s;
    assign sm_sum  = 43'(p1_reg) + (43'(p2) <<< 8) + 43'sd128;

    // rounded display value: floor((s + 128) / 256), then saturate
    assign sh_sum  = (SMOOTH_W+1)'(smooth_reg) + (SMOOTH_W+1)'(128);
    assign shown   = sh_sum[SMOOTH_W:8];
    always_comb begin
        if (shown[SPEED_W] != shown[SPEED_W-1]) begin
            shown_sat = shown[SPEED_W] ? signed'(NEG_LIMIT[SPEED_W-1:0])
                                       : signed'(POS_LIMIT[SPEED_W-1:0]);
        end else begin
            shown_sat = shown[SPEED_W-1:0];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_prev_reg  <= 1'b0;
            pos_reg       <= '0;
            count_reg     <= '0;
            last_time_reg <= '0;
            smooth_reg    <= '0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
        end else begin
            va_reg <= cmd.sum_step;
            vb_reg <= va_reg;
            if (cmd.check) begin
                has_prev_reg <= 1'b1;
                if (!has_prev_reg) begin
                    pos_reg <= POS_W'(angle_reg);
                end else begin
                    pos_reg <= pos_reg + POS_W'(signed'(ang_d));
                end
            end
            if (cmd.drop) begin
                count_reg <= count_reg - CNT_W'(1);
            end else if (cmd.append) begin
                count_reg     <= count_reg + CNT_W'(1);
                last_time_reg <= now_reg;
            end
            if (cmd.smooth2) begin
                smooth_reg <= sm_sum[39:8];
            end
        end
    end

    // window store: drop shifts toward the oldest slot
    always_ff @(posedge aclk) begin
        if (cmd.drop) begin
            for (int i = 0; i < MAX_SAMPLES - 1; i++) begin
                win_pos_reg[i]  <= win_pos_reg[i+1];
                win_time_reg[i] <= win_time_reg[i+1];
            end
        end else if (cmd.append) begin
            win_pos_reg[count_reg[IDX_W-1:0]]  <= pos_reg;
            win_time_reg[count_reg[IDX_W-1:0]] <= now_reg;
        end
    end

    // payload and arithmetic pipeline
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            angle_reg <= s_angle_count;
            now_reg   <= s_time_ms;
        end
        if (cmd.check) begin
            taken_reg <= sta.accept;
        end
        if (cmd.append) begin
            idx_reg <= '0;
            st_reg  <= '0;
            sp_reg  <= '0;
            stp_reg <= '0;
            st2_reg <= '0;
        end else begin
            if (cmd.sum_step) begin
                idx_reg <= idx_reg + IDX_W'(1);
                ta_reg  <= signed'({1'b0, t_sat});
                pa_reg  <= signed'(win_pos_reg[idx_reg] - win_pos_reg[0]);
            end
            if (va_reg) begin
                tp_reg <= ta_reg * pa_reg;
                tt_reg <= ta_reg * ta_reg;
                tb_reg <= ta_reg;
                pb_reg <= pa_reg;
            end
            if (vb_reg) begin
                st_reg  <= st_reg + ST_W'(tb_reg);
                sp_reg  <= sp_reg + SP_W'(pb_reg);
                stp_reg <= stp_reg + STP_W'(tp_reg);
                st2_reg <= st2_reg + ST2_W'(tt_reg);
            end
        end
        if (cmd.prod) begin
            prod_a_reg <= n_s * stp_reg;
            prod_b_reg <= st_reg * sp_reg;
            prod_c_reg <= n_s * st2_reg;
            prod_d_reg <= st_reg * st_reg;
        end
        if (cmd.diff) begin
            num_reg     <= (PW+1)'(prod_a_reg) - (PW+1)'(prod_b_reg);
            den_reg     <= (PW+1)'(prod_c_reg) - (PW+1)'(prod_d_reg);
            den_pos_reg <= (prod_c_reg > prod_d_reg);
        end
        // a * 15000 = a*16384 - a*(1024 + 256 + 64 + 32 + 8)
        if (cmd.scale1) begin
            neg_reg <= num_reg[PW];
            a_reg   <= ax;
            tmp_reg <= (ax << 14) - (ax << 10) - (ax << 8);
            dv_reg  <= DIV_W'(unsigned'(den_reg)) << 6;
        end
        if (cmd.scale2) begin
            quo_reg  <= tmp_reg - (a_reg << 6) - (a_reg << 5) - (a_reg << 3)
                        + (dv_reg >> 1);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= ge ? DIV_W'(rem_sh - {1'b0, dv_reg}) : rem_sh[DIV_W-1:0];
            quo_reg  <= {quo_reg[DIV_W-2:0], ge};
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
        if (cmd.smooth1) begin
            raw_reg <= raw;
            p1_reg  <= smooth_reg * w_s;
        end
        if (cmd.out_load) begin
            m_speed_rpm    <= shown_sat;
            m_sample_taken <= taken_reg;
        end
    end

endmodule

[rtl/windowed_regression_velocity.sv]
// A rejected sample goes from the check state straight to the result transfer;
// an accepted one also passes the drops (per dropped entry), the regression sums
// (per window entry after the append), scaling, serial division and smoothing.
// No new sample is taken before its result is loaded; a held result stalls the input.
// Reset (aresetn low, synchronous) clears the window, position, smoothed
// speed and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// windowed_regression_velocity
// Least-squares velocity estimator over a time-limited sample window with
// exponential smoothing of the speed in 1/16 rpm.
// ----------------------------------------------------------------------------
module windowed_regression_velocity #(
    parameter int MAX_SAMPLES = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [wrv_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [wrv_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [wrv_pkg::ANGLE_W-1:0]           s_angle_count,
    input  logic [wrv_pkg::TIME_W-1:0]            s_time_ms,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [wrv_pkg::SPEED_W-1:0]    m_speed_rpm,
    output logic                                  m_sample_taken
);
    import wrv_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sta_t sta;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_ms       <= WINDOW_MS_RST;
            cfg_reg.sample_count    <= SAMPLE_COUNT_RST;
            cfg_reg.min_interval_ms <= MIN_INTERVAL_RST;
            cfg_reg.smoothing_alpha <= ALPHA_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WINDOW_MS:    cfg_reg.window_ms       <= cfg_wr_data;
                REG_SAMPLE_COUNT: cfg_reg.sample_count    <= cfg_wr_data[CNT_CFG_W-1:0];
                REG_MIN_INTERVAL: cfg_reg.min_interval_ms <= cfg_wr_data[MINT_W-1:0];
                REG_ALPHA:        cfg_reg.smoothing_alpha <= cfg_wr_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    wrv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sta     (sta),
        .cmd     (cmd)
    );

    wrv_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sta            (sta),
        .s_angle_count  (s_angle_count),
        .s_time_ms      (s_time_ms),
        .m_speed_rpm    (m_speed_rpm),
        .m_sample_taken (m_sample_taken)
    );

    // a transfer in starts a job: no second input until it finishes
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a sample is in progress");

    // a new result only comes out of a job, never from idle
    a_result_from_job: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised without a sample in progress");

    // window entries drop only when aged out or over capacity
    a_drop_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drop |-> (sta.age_over || sta.cap_full))
        else $error("window entry dropped without cause");

endmodule

[dv/tb_windowed_regression_velocity.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_regression_velocity
// Self-checking bench for the windowed regression velocity estimator. Drives
// angle/timestamp samples in bursts with random gaps and a randomly stalling
// result side, predicts the unwrap, window, least-squares slope and smoothing
// in a scoreboard, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_windowed_regression_velocity;
    import wrv_pkg::*;

    localparam int WIN_DEPTH = 8;
    localparam int STALL_LIMIT = 20000;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 4'd9;

    class speed_scoreboard;
        logic [WIN_W-1:0]     win_ms;
        logic [CNT_CFG_W-1:0] depth_cfg;
        logic [MINT_W-1:0]    min_gap;
        logic [ALPHA_W-1:0]   alpha_cfg;

        bit          seen_first;
        bit [31:0]   position;
        bit [31:0]   hist_pos[WIN_DEPTH];
        bit [31:0]   hist_time[WIN_DEPTH];
        int unsigned fill;
        bit [31:0]   last_time;
        int          smooth;

        logic signed [SPEED_W-1:0] exp_speed[$];
        bit                        exp_taken[$];
        int                        fails;

        function new();
            fails = 0;
            clear();
        endfunction

        function void clear();
            win_ms = WINDOW_MS_RST;
            depth_cfg = SAMPLE_COUNT_RST;
            min_gap = MIN_INTERVAL_RST;
            alpha_cfg = ALPHA_RST;
            seen_first = 0;
            position = 0;
            fill = 0;
            last_time = 0;
            smooth = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_WINDOW_MS:    win_ms = val[WIN_W-1:0];
                REG_SAMPLE_COUNT: depth_cfg = val[CNT_CFG_W-1:0];
                REG_MIN_INTERVAL: min_gap = val[MINT_W-1:0];
                REG_ALPHA:        alpha_cfg = val[ALPHA_W-1:0];
                default: ;
            endcase
        endfunction

        function void shift_out();
            for (int i = 0; i + 1 < fill; i++) begin
                hist_pos[i] = hist_pos[i+1];
                hist_time[i] = hist_time[i+1];
            end
            fill--;
        endfunction

        function longint slope_speed();
            longint n, st, sp, stp, st2, t, p, num, den;
            longint unsigned a, d, q, r, mag;
            bit [31:0] dt;
            bit neg;
            if (fill < 2) return 0;
            n = fill;
            st = 0; sp = 0; stp = 0; st2 = 0;
            for (int i = 0; i < fill; i++) begin
                dt = hist_time[i] - hist_time[0];
                t = (dt > 32'd65535) ? 65535 : longint'(dt);
                p = longint'(int'(hist_pos[i] - hist_pos[0]));
                st += t; sp += p; stp += t * p; st2 += t * t;
            end
            num = n * stp - st * sp;
            den = n * st2 - st * st;
            if (den <= 0) return 0;
            neg = num < 0;
            a = neg ? longint'(-num) : num;
            d = den * 64;
            q = a / d;
            r = a % d;
            if (q >= 64'd16777216) mag = 64'd16777216;
            else mag = q * 15000 + (r * 15000 + d / 2) / d;
            if (neg) return (mag > 64'd8388608) ? -8388608 : -longint'(mag);
            return (mag > 64'd8388607) ? 8388607 : longint'(mag);
        endfunction

        function void note_sample(logic [ANGLE_W-1:0] angle, logic [TIME_W-1:0] now);
            bit [11:0] d;
            bit taken;
            int unsigned cap, alpha;
            longint s, shown;
            if (!seen_first) begin
                seen_first = 1;
                position = 32'(angle);
            end else begin
                d = angle - position[11:0];
                position += {{20{d[11]}}, d};
            end
            taken = 1;
            if (fill > 0) begin
                if (hist_time[fill-1] == now) taken = 0;
                else if (now - last_time < min_gap) taken = 0;
            end
            if (taken) begin
                cap = depth_cfg;
                if (cap < 2) cap = 2;
                if (cap > WIN_DEPTH) cap = WIN_DEPTH;
                alpha = (alpha_cfg > ALPHA_ONE) ? 256 : alpha_cfg;
                while (fill > 0 && now - hist_time[0] > {16'd0, win_ms}) shift_out();
                while (fill >= cap) shift_out();
                hist_pos[fill] = position;
                hist_time[fill] = now;
                fill++;
                last_time = now;
                s = longint'(smooth) * (256 - alpha) + slope_speed() * 256 * alpha;
                smooth = int'((s + 128) >>> 8);
            end
            shown = (longint'(smooth) + 128) >>> 8;
            if (shown > 8388607) shown = 8388607;
            if (shown < -8388608) shown = -8388608;
            exp_speed.push_back(shown[SPEED_W-1:0]);
            exp_taken.push_back(taken);
        endfunction

        function void check_result(logic signed [SPEED_W-1:0] speed, logic taken);
            logic signed [SPEED_W-1:0] want_speed;
            bit want_taken;
            if (exp_speed.size() == 0) begin
                $error("result with nothing expected: speed_rpm=%0d sample_taken=%0b",
                       speed, taken);
                fails++;
                return;
            end
            want_speed = exp_speed.pop_front();
            want_taken = exp_taken.pop_front();
            if (speed !== want_speed) begin
                $error("speed_rpm: expected %0d, got %0d", want_speed, speed);
                fails++;
            end
            if (taken !== want_taken) begin
                $error("sample_taken: expected %0b, got %0b", want_taken, taken);
                fails++;
            end
        endfunction

        function int pending();
            return exp_speed.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [CFG_DATA_W-1:0]     cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [ANGLE_W-1:0]        s_angle_count;
    logic [TIME_W-1:0]         s_time_ms;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [SPEED_W-1:0] m_speed_rpm;
    logic                      m_sample_taken;

    speed_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  hold_req = 0;
    int  burst_left = 0;
    logic [ANGLE_W-1:0] cur_angle = 0;
    logic [TIME_W-1:0]  cur_time = 0;

    windowed_regression_velocity DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_angle_count(s_angle_count), .s_time_ms(s_time_ms),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_speed_rpm(m_speed_rpm), .m_sample_taken(m_sample_taken)
    );

    initial aclk = 0;
    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // transfer monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_sample(s_angle_count, s_time_ms);
            if (m_valid && m_ready) sb.check_result(m_speed_rpm, m_sample_taken);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: stall rate redrawn at random, periodically; long hold on request
    always begin
        int stall_pct, hold_cnt;
        stall_pct = 0;
        hold_cnt = 0;
        forever begin
            for (int i = 0; i < 400; i++) begin
                @(negedge aclk);
                if (hold_req && hold_cnt == 0) begin
                    hold_cnt = 3000;
                    hold_req = 0;
                end
                if (hold_cnt > 0) begin
                    hold_cnt--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= ($urandom_range(0, 99) >= stall_pct);
                end
            end
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(logic [ANGLE_W-1:0] angle, logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_angle_count <= angle;
        s_time_ms <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (130) @(posedge aclk);
    endtask

    task automatic set_config(int win, int cnt, int gap, int alpha);
        write_reg(REG_WINDOW_MS, CFG_DATA_W'(win));
        write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(cnt));
        write_reg(REG_MIN_INTERVAL, CFG_DATA_W'(gap));
        write_reg(REG_ALPHA, CFG_DATA_W'(alpha));
    endtask

    // motion with random speed and noise; occasional repeats, back steps,
    // far time jumps and random angles
    task automatic run_motion(int items, int step_max);
        int vel, dt, kind, noise;
        vel = $urandom_range(0, 1200) - 600;
        for (int k = 0; k < items; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 4) dt = 0;
            else if (kind < 7) dt = -$urandom_range(1, 500);
            else dt = $urandom_range(1, step_max);
            if (kind == 7) cur_time = $urandom();
            else cur_time = cur_time + TIME_W'(dt);
            noise = $urandom_range(0, 8) - 4;
            if (kind == 8 || kind == 9) cur_angle = ANGLE_W'($urandom_range(0, 4095));
            else cur_angle = cur_angle + ANGLE_W'(((vel * dt) / 100) + noise);
            if ($urandom_range(0, 49) == 0) vel = $urandom_range(0, 1200) - 600;
            send_sample(cur_angle, cur_time);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_angle_count = '0;
        s_time_ms = '0;
        m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: first sample, half turn, repeated time, short interval,
        // time wrap, time going back, full-scale fields
        send_sample(12'd0, 32'd0);
        send_sample(12'd2048, 32'd30);
        send_sample(12'd4095, 32'd30);
        send_sample(12'd100, 32'd40);
        send_sample(12'd4000, 32'd60);
        send_sample(12'd10, 32'd5);
        send_sample(12'd2047, 32'hFFFF_FFF0);
        send_sample(12'd3000, 32'h0000_0010);
        send_sample(12'd1000, 32'h0001_5000);
        drain();
        // alpha above one, capacity below range, 1 ms window, no min gap
        set_config(1, 0, 0, 511);
        write_reg(REG_SPARE, 16'hFFFF);
        send_sample(12'd500, 32'd1000);
        send_sample(12'd900, 32'd1001);
        send_sample(12'd1300, 32'd1002);
        send_sample(12'd1700, 32'd1004);
        drain();
        // capacity above range, longest window, alpha zero then full
        set_config(65535, 15, 255, 0);
        for (int k = 0; k < 6; k++) send_sample(12'(k * 700), 32'(2000 + k * 300));
        drain();
        write_reg(REG_ALPHA, 16'd256);
        for (int k = 0; k < 6; k++) send_sample(12'(k * 1500), 32'(5000 + k * 255));
        drain();

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_config(200, 5, 20, 51);
                1: set_config(65535, 8, 0, 256);
                2: set_config(1, 2, 255, 0);
                3: set_config(65535, 2, 0, 128);
                default: set_config($urandom_range(20, 2000), $urandom_range(0, 15),
                                    $urandom_range(0, 40), $urandom_range(0, 300));
            endcase
            if (ph == 4) hold_req = 1;
            run_motion(133, (ph == 2) ? 400 : 60);
            drain();
        end

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[windowed_regression_velocity.f]
rtl/wrv_pkg.sv
rtl/wrv_ctrl.sv
rtl/wrv_dp.sv
rtl/windowed_regression_velocity.sv
dv/tb_windowed_regression_velocity.sv
